@@ rtl/sobel_edge_magnitude_defines.svh @@
// assertion macros shared by the sobel edge magnitude rtl
// needs a clock named clk and a reset named rst in the using module
`ifndef SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`ifndef SYNTHESIS
`define SEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SEM_ASSERT(lbl, prop, msg)
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/sem_pkg.sv @@
// types and constants for the sobel edge magnitude block
// no dependencies
`default_nettype none
package sem_pkg;
  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int LUMA_W    = 16;
  localparam int MAG_W     = 19;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  localparam logic [7:0] COEF_R = 8'd77;
  localparam logic [7:0] COEF_G = 8'd150;
  localparam logic [7:0] COEF_B = 8'd29;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic             center_valid;
    logic [10:0]      center_col;
    logic [15:0]      center_row;
    logic [MAG_W-1:0] edge_mag;
    logic [MAG_W-1:0] frame_max;
    logic             frame_done;
  } res_t;
endpackage
`default_nettype wire

@@ rtl/sem_isqrt.sv @@
// iterative floor square root, two radicand bits per cycle
// uses sem_pkg widths
`default_nettype none
module sem_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sem_pkg::SQ_W-1:0]  value,
  output logic                      done,
  output logic [sem_pkg::MAG_W-1:0] root
);
  logic                      busy;
  logic [4:0]                cnt;
  logic [sem_pkg::SQ_W-1:0]  val;
  logic [sem_pkg::MAG_W:0]   rem;
  logic [sem_pkg::MAG_W+2:0] rem_sh;
  logic [sem_pkg::MAG_W+2:0] trial;
  logic                      fits;

  // one restoring step
  always_comb begin
    rem_sh = {rem, val[sem_pkg::SQ_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(sem_pkg::MAG_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val <= {val[sem_pkg::SQ_W-3:0], 2'b00};
      if (fits) begin
        rem  <= (sem_pkg::MAG_W+1)'(rem_sh - trial);
        root <= {root[sem_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[sem_pkg::MAG_W:0];
        root <= {root[sem_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/sobel_edge_magnitude.sv @@
// channel | dir | handshake           | word
// in      | in  | in_valid/in_ready   | pix_t: red, green, blue
// out     | out | out_valid/out_ready | res_t: centre, magnitude, frame max, done
// cfg     | in  | cfg_we              | cfg_index, cfg_data
// a pixel's result word is built in steps after it is accepted: line store
// read, window update and write back, gradients, squares, root start, the
// iterative square root, then loading the output word; a new pixel is
// taken only after the previous pixel's output word is loaded
// rst clears counters, window and running max, sets width/height to reset values;
// line stores are not cleared; a held output word stalls the next pixel's end
// uses sem_pkg, sem_isqrt and sobel_edge_magnitude_defines.svh
`default_nettype none
`include "sobel_edge_magnitude_defines.svh"
module sobel_edge_magnitude (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sem_pkg::pix_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sem_pkg::res_t                 out_data,
  input  logic                          cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_GRAD = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]  state;
  logic [11:0] image_width;
  logic [15:0] image_height;
  logic [11:0] w_eff;
  logic [15:0] h_eff;
  logic [sem_pkg::ADDR_W-1:0] col_count;
  logic [15:0] row_count;
  logic [sem_pkg::MAG_W-1:0] running_max;

  logic [sem_pkg::LUMA_W-1:0] upper_mem  [sem_pkg::MAX_WIDTH];
  logic [sem_pkg::LUMA_W-1:0] middle_mem [sem_pkg::MAX_WIDTH];
  logic [sem_pkg::LUMA_W-1:0] rd_upper;
  logic [sem_pkg::LUMA_W-1:0] rd_middle;
  logic [sem_pkg::LUMA_W-1:0] luma;
  logic [sem_pkg::LUMA_W-1:0] luma_q;
  logic [sem_pkg::LUMA_W-1:0] win [9];

  logic signed [19:0] gx;
  logic signed [19:0] gy;
  logic [17:0] ax;
  logic [17:0] ay;
  logic [35:0] ax2;
  logic [35:0] ay2;
  logic        sq_start;
  logic        sq_done;
  logic [sem_pkg::MAG_W-1:0] sq_root;
  logic        interior;
  logic        center_ok;
  logic [sem_pkg::MAG_W-1:0] mag;
  logic [sem_pkg::MAG_W-1:0] max_next;
  logic        last_col;
  logic        last_row;
  logic        in_fire;
  logic        out_free;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // effective frame size
  always_comb begin
    w_eff = image_width;
    if (image_width < 12'd3) w_eff = 12'd3;
    if (image_width > 12'(sem_pkg::MAX_WIDTH)) w_eff = 12'(sem_pkg::MAX_WIDTH);
    h_eff = (image_height < 16'd3) ? 16'd3 : image_height;
  end

  // luma of the incoming pixel
  assign luma = 16'({8'd0, in_data.red} * {8'd0, sem_pkg::COEF_R})
              + 16'({8'd0, in_data.green} * {8'd0, sem_pkg::COEF_G})
              + 16'({8'd0, in_data.blue} * {8'd0, sem_pkg::COEF_B});

  // line stores: read at accept, write back in the cycle after
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_upper  <= upper_mem[col_count];
      rd_middle <= middle_mem[col_count];
      luma_q    <= luma;
    end
    if (state == S_READ) begin
      upper_mem[col_count]  <= rd_middle;
      middle_mem[col_count] <= luma_q;
    end
  end

  // 3x3 window shift, new column on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (state == S_READ) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3]   <= win[i*3+1];
        win[i*3+1] <= win[i*3+2];
      end
      win[2] <= rd_upper;
      win[5] <= rd_middle;
      win[8] <= luma_q;
    end
  end

  // sobel gradients
  always_comb begin
    gx = (20'(win[2]) - 20'(win[0])) + ((20'(win[5]) - 20'(win[3])) <<< 1)
       + (20'(win[8]) - 20'(win[6]));
    gy = (20'(win[6]) + (20'(win[7]) <<< 1) + 20'(win[8]))
       - (20'(win[0]) + (20'(win[1]) <<< 1) + 20'(win[2]));
  end

  // absolute values, then squares
  always_ff @(posedge clk) begin
    if (state == S_GRAD) begin
      ax <= gx[19] ? 18'(-gx) : gx[17:0];
      ay <= gy[19] ? 18'(-gy) : gy[17:0];
    end
    if (state == S_SQR) begin
      ax2 <= ax * ax;
      ay2 <= ay * ay;
    end
  end

  assign sq_start = (state == S_SUM);

  sem_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sem_pkg::SQ_W'(ax2) + sem_pkg::SQ_W'(ay2)),
    .done  (sq_done),
    .root  (sq_root)
  );

  // result of the current pixel
  always_comb begin
    center_ok = (col_count >= 11'd1) && (row_count >= 16'd1);
    interior  = (col_count >= 11'd2) && (row_count >= 16'd2);
    mag       = interior ? sq_root : '0;
    max_next  = (mag > running_max) ? mag : running_max;
    last_col  = (12'(col_count) + 12'd1 >= w_eff);
    last_row  = (17'(row_count) + 17'd1 >= 17'(h_eff));
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= sem_pkg::WIDTH_RESET;
      image_height <= sem_pkg::HEIGHT_RESET;
      col_count    <= '0;
      row_count    <= '0;
      running_max  <= '0;
      out_valid    <= 1'b0;
    end else begin
      // output word valid: load wins over a taken word
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_we && (cfg_index == sem_pkg::REG_WIDTH || cfg_index == sem_pkg::REG_HEIGHT))
      begin
        if (cfg_index == sem_pkg::REG_WIDTH) image_width <= cfg_data[11:0];
        else image_height <= cfg_data;
        col_count   <= '0;
        row_count   <= '0;
        running_max <= '0;
      end
      case (state)
        S_IDLE: if (in_fire) state <= S_READ;
        S_READ: state <= S_GRAD;
        S_GRAD: state <= S_SQR;
        S_SQR:  state <= S_SUM;
        S_SUM:  state <= S_ROOT;
        S_ROOT: if (sq_done) state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
            if (last_col) begin
              col_count <= '0;
              if (last_row) begin
                row_count   <= '0;
                running_max <= '0;
              end else begin
                row_count   <= row_count + 16'd1;
                running_max <= max_next;
              end
            end else begin
              col_count   <= col_count + 11'd1;
              running_max <= max_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_data.center_valid <= center_ok;
      out_data.center_col   <= center_ok ? col_count - 11'd1 : '0;
      out_data.center_row   <= center_ok ? row_count - 16'd1 : '0;
      out_data.edge_mag     <= mag;
      out_data.frame_max    <= max_next;
      out_data.frame_done   <= (12'(col_count) + 12'd1 >= w_eff)
                               && (17'(row_count) + 17'd1 >= 17'(h_eff));
    end
  end

  `SEM_ASSERT_NEXT(a_accept_reads, in_fire, state == S_READ, "accept did not start a read")
  `SEM_ASSERT(a_col_in_range, (state != S_IDLE) || (12'(col_count) < w_eff), "column past width")
  `SEM_ASSERT(a_max_covers_mag, !out_valid || (out_data.frame_max >= out_data.edge_mag),
    "frame max below edge magnitude")
  `SEM_ASSERT(a_root_only_waiting, !sq_done || (state == S_ROOT), "root finished out of turn")
endmodule
`default_nettype wire
